// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the allocator's RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- rtl/ffba_pkg.sv -----
// Shared widths, defaults and controller/datapath interface types for the allocator.
package ffba_pkg;

    localparam int DEF_NUM_BLOCKS = 1024;

    localparam int REQ_W   = 11;
    localparam int START_W = 10;
    localparam int COUNT_W = 11;
    localparam int RUNS_W  = 10;
    localparam int AVG_W   = 19;

    // Fraction bits of the average run length.
    localparam int FRAC_W = 8;

    typedef struct packed {
        logic clear;
        logic load;
        logic scan;
        logic mark;
        logic stats_init;
        logic stats;
        logic div_init;
        logic div;
    } ffba_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic req_bad;
        logic hit;
        logic miss;
        logic mark_last;
        logic stats_last;
        logic div_last;
    } ffba_status_t;

endpackage

// ----- rtl/first_fit_block_allocator.sv -----
// Top level of the first-fit contiguous block allocator.
//
// Usage: drive request_size and pulse start while busy is low; the word is
// taken at that rising edge. The block scans its block map from block 0 for
// the first run of request_size free blocks, marks it used, then counts free
// blocks and free runs over the whole map and divides to get the average run
// length. The result word on granted, first_block, free_count, run_count,
// average_run_q8 and waste_count is flagged by done, which is high for a
// single cycle; the receiver cannot stall, so it must take the word that cycle.
// A zero or oversized request skips the scan and the marking. The single-port
// block map memory is read one block per cycle by the scan and the statistics
// pass and written one block per cycle while marking. One request is in flight
// at a time, and busy stays high until done has been shown.
// After reset the block clears the map to all free, with busy high, before it
// takes its first request.
module first_fit_block_allocator #(
    parameter int NUM_BLOCKS = ffba_pkg::DEF_NUM_BLOCKS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [ffba_pkg::REQ_W-1:0]    request_size,
    output logic                          done,
    output logic                          granted,
    output logic [ffba_pkg::START_W-1:0]  first_block,
    output logic [ffba_pkg::COUNT_W-1:0]  free_count,
    output logic [ffba_pkg::RUNS_W-1:0]   run_count,
    output logic [ffba_pkg::AVG_W-1:0]    average_run_q8,
    output logic [ffba_pkg::COUNT_W-1:0]  waste_count
);
    import ffba_pkg::*;

    // Commands flow from the sequencer to the datapath, status flows back.
    ffba_cmd_t    cmd;
    ffba_status_t st;

    ffba_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .st    (st),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    // The datapath holds the map memory and all counters; its result
    // registers stay stable through the done cycle.
    ffba_dp #(
        .NUM_BLOCKS (NUM_BLOCKS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .st             (st),
        .request_size   (request_size),
        .granted        (granted),
        .first_block    (first_block),
        .free_count     (free_count),
        .run_count      (run_count),
        .average_run_q8 (average_run_q8),
        .waste_count    (waste_count)
    );

endmodule

// ----- rtl/ffba_ctrl.sv -----
// Sequencing state machine of the allocator: clear, scan, mark, statistics, divide.
`include "assert_macros.svh"

module ffba_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  ffba_pkg::ffba_status_t st,
    output ffba_pkg::ffba_cmd_t   cmd,
    output logic                  busy,
    output logic                  done
);
    import ffba_pkg::*;

    typedef enum logic [8:0] {
        ST_CLEAR      = 9'b000000001,
        ST_IDLE       = 9'b000000010,
        ST_SCAN       = 9'b000000100,
        ST_MARK       = 9'b000001000,
        ST_STATS_INIT = 9'b000010000,
        ST_STATS      = 9'b000100000,
        ST_DIV_INIT   = 9'b001000000,
        ST_DIV        = 9'b010000000,
        ST_DONE       = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (st.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                priority if (st.req_bad)
                begin
                    state_next = ST_STATS_INIT;
                end
                else if (st.hit)
                begin
                    state_next = ST_MARK;
                end
                else if (st.miss)
                begin
                    state_next = ST_STATS_INIT;
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_MARK:
            begin
                cmd.mark = 1'b1;
                if (st.mark_last)
                begin
                    state_next = ST_STATS_INIT;
                end
            end
            ST_STATS_INIT:
            begin
                cmd.stats_init = 1'b1;
                state_next     = ST_STATS;
            end
            ST_STATS:
            begin
                cmd.stats = 1'b1;
                if (st.stats_last)
                begin
                    state_next = ST_DIV_INIT;
                end
            end
            ST_DIV_INIT:
            begin
                cmd.div_init = 1'b1;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div = 1'b1;
                if (st.div_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = (state_reg == ST_DONE);

    `ASSERT_NEXT(a_done_single, clk, rst_n, done, !done)
    `ASSERT_NEXT(a_accept_scans, clk, rst_n, start && !busy, state_reg == ST_SCAN)
    `ASSERT_NEXT(a_div_to_done, clk, rst_n, cmd.div && st.div_last, done)

endmodule

// ----- rtl/ffba_dp.sv -----
// Datapath of the allocator: block map memory, run scan, marking, statistics and divider.
`include "assert_macros.svh"

module ffba_dp #(
    parameter int NUM_BLOCKS = ffba_pkg::DEF_NUM_BLOCKS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ffba_pkg::ffba_cmd_t           cmd,
    output ffba_pkg::ffba_status_t        st,
    input  logic [ffba_pkg::REQ_W-1:0]    request_size,
    output logic                          granted,
    output logic [ffba_pkg::START_W-1:0]  first_block,
    output logic [ffba_pkg::COUNT_W-1:0]  free_count,
    output logic [ffba_pkg::RUNS_W-1:0]   run_count,
    output logic [ffba_pkg::AVG_W-1:0]    average_run_q8,
    output logic [ffba_pkg::COUNT_W-1:0]  waste_count
);
    import ffba_pkg::*;

    localparam int IW  = $clog2(NUM_BLOCKS);
    localparam int CW  = $clog2(NUM_BLOCKS + 1);
    localparam int LW  = (CW > REQ_W) ? CW : REQ_W;
    localparam int QW  = CW + FRAC_W;
    localparam int DCW = $clog2(QW + 1);

    localparam logic [IW-1:0]  LAST_IDX = IW'(NUM_BLOCKS - 1);
    localparam logic [LW-1:0]  MAX_LEN  = LW'(NUM_BLOCKS);
    localparam logic [DCW-1:0] DIV_LAST = DCW'(QW - 1);

    // Block map, one bit per block, 1 means used.
    logic mem [NUM_BLOCKS];
    logic mem_we;
    logic mem_wd;

    logic [IW-1:0]    addr_reg, addr_next;
    logic             issue_done_reg, issue_done_next;
    logic             rd_vld_reg, rd_vld_next;
    logic [IW-1:0]    rd_idx_reg;
    logic             rd_data_reg;

    logic [REQ_W-1:0] len_reg, len_next;
    logic [CW-1:0]    run_reg, run_next;
    logic [IW-1:0]    run_start_reg, run_start_next;
    logic             granted_reg, granted_next;
    logic [IW-1:0]    start_reg, start_next;
    logic [CW-1:0]    left_reg, left_next;
    logic [CW-1:0]    free_reg, free_next;
    logic [CW-1:0]    runs_reg, runs_next;
    logic             prev_used_reg, prev_used_next;
    logic [CW-1:0]    rem_reg, rem_next;
    logic [QW-1:0]    quo_reg, quo_next;
    logic [DCW-1:0]   div_cnt_reg, div_cnt_next;

    logic [LW-1:0]    len_ext;
    logic [LW-1:0]    run_inc;
    logic             req_bad;
    logic             hit_now;
    logic             at_last;
    logic [CW:0]      trial;
    logic [CW:0]      diff;
    logic [CW-1:0]    whole;

    assign len_ext = LW'(len_reg);
    assign run_inc = LW'(run_reg) + LW'(1);
    assign req_bad = (len_reg == '0) || (len_ext > MAX_LEN);
    assign at_last = rd_vld_reg && (rd_idx_reg == LAST_IDX);
    assign hit_now = cmd.scan && !req_bad && rd_vld_reg && !rd_data_reg && (run_inc == len_ext);

    // One restoring division step: shift in the next dividend bit and try a subtract.
    assign trial = {rem_reg, quo_reg[QW-1]};
    assign diff  = trial - {1'b0, runs_reg};

    always_comb
    begin
        st            = '0;
        st.clear_last = cmd.clear && (addr_reg == LAST_IDX);
        st.req_bad    = req_bad;
        st.hit        = hit_now;
        st.miss       = cmd.scan && at_last && !hit_now;
        st.mark_last  = cmd.mark && (left_reg == CW'(1));
        st.stats_last = cmd.stats && at_last;
        st.div_last   = cmd.div && (div_cnt_reg == DIV_LAST);
    end

    always_comb
    begin
        addr_next       = addr_reg;
        issue_done_next = issue_done_reg;
        rd_vld_next     = 1'b0;
        len_next        = len_reg;
        run_next        = run_reg;
        run_start_next  = run_start_reg;
        granted_next    = granted_reg;
        start_next      = start_reg;
        left_next       = left_reg;
        free_next       = free_reg;
        runs_next       = runs_reg;
        prev_used_next  = prev_used_reg;
        rem_next        = rem_reg;
        quo_next        = quo_reg;
        div_cnt_next    = div_cnt_reg;
        mem_we          = 1'b0;
        mem_wd          = 1'b0;

        // Sequential read issue shared by the scan and the statistics pass.
        if ((cmd.scan || cmd.stats) && !issue_done_reg)
        begin
            rd_vld_next = 1'b1;
            addr_next   = addr_reg + IW'(1);
            if (addr_reg == LAST_IDX)
            begin
                issue_done_next = 1'b1;
            end
        end

        if (cmd.clear)
        begin
            mem_we    = 1'b1;
            mem_wd    = 1'b0;
            addr_next = addr_reg + IW'(1);
        end

        if (cmd.load)
        begin
            len_next        = request_size;
            addr_next       = '0;
            issue_done_next = 1'b0;
            rd_vld_next     = 1'b0;
            run_next        = '0;
            granted_next    = 1'b0;
            start_next      = '0;
        end

        if (cmd.scan && rd_vld_reg)
        begin
            if (rd_data_reg)
            begin
                run_next = '0;
            end
            else
            begin
                run_next = run_reg + CW'(1);
                if (run_reg == '0)
                begin
                    run_start_next = rd_idx_reg;
                end
            end
        end

        // A hit points the address counter at the run start for marking.
        if (hit_now)
        begin
            granted_next = 1'b1;
            start_next   = (run_reg == '0) ? rd_idx_reg : run_start_reg;
            addr_next    = (run_reg == '0) ? rd_idx_reg : run_start_reg;
            left_next    = CW'(len_reg);
        end

        if (cmd.mark)
        begin
            mem_we    = 1'b1;
            mem_wd    = 1'b1;
            addr_next = addr_reg + IW'(1);
            left_next = left_reg - CW'(1);
        end

        if (cmd.stats_init)
        begin
            addr_next       = '0;
            issue_done_next = 1'b0;
            rd_vld_next     = 1'b0;
            free_next       = '0;
            runs_next       = '0;
            prev_used_next  = 1'b1;
        end

        if (cmd.stats && rd_vld_reg)
        begin
            prev_used_next = rd_data_reg;
            if (!rd_data_reg)
            begin
                free_next = free_reg + CW'(1);
                if (prev_used_reg)
                begin
                    runs_next = runs_reg + CW'(1);
                end
            end
        end

        if (cmd.div_init)
        begin
            rem_next     = '0;
            quo_next     = {free_reg, {FRAC_W{1'b0}}};
            div_cnt_next = '0;
        end

        if (cmd.div)
        begin
            div_cnt_next = div_cnt_reg + DCW'(1);
            if (!diff[CW])
            begin
                rem_next = diff[CW-1:0];
                quo_next = {quo_reg[QW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[CW-1:0];
                quo_next = {quo_reg[QW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg       <= '0;
            issue_done_reg <= 1'b0;
            rd_vld_reg     <= 1'b0;
        end
        else
        begin
            addr_reg       <= addr_next;
            issue_done_reg <= issue_done_next;
            rd_vld_reg     <= rd_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg    <= addr_reg;
        len_reg       <= len_next;
        run_reg       <= run_next;
        run_start_reg <= run_start_next;
        granted_reg   <= granted_next;
        start_reg     <= start_next;
        left_reg      <= left_next;
        free_reg      <= free_next;
        runs_reg      <= runs_next;
        prev_used_reg <= prev_used_next;
        rem_reg       <= rem_next;
        quo_reg       <= quo_next;
        div_cnt_reg   <= div_cnt_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[addr_reg] <= mem_wd;
        end
        rd_data_reg <= mem[addr_reg];
    end

    assign whole = quo_reg[QW-1:FRAC_W];

    assign granted        = granted_reg;
    assign first_block    = START_W'(start_reg);
    assign free_count     = COUNT_W'(free_reg);
    assign run_count      = RUNS_W'(runs_reg);
    assign average_run_q8 = (runs_reg == '0) ? '0 : AVG_W'(quo_reg);
    assign waste_count    = (runs_reg == '0) ? '0 : COUNT_W'(free_reg - whole);

    `ASSERT_IMPLIES(a_mark_granted, clk, rst_n, cmd.mark, granted_reg)
    `ASSERT_IMPLIES(a_mark_left, clk, rst_n, cmd.mark, left_reg != '0)
    `ASSERT_IMPLIES(a_hit_valid_len, clk, rst_n, hit_now, !req_bad)

endmodule
